@@ rtl/core/rgb565_pixel_blend_macros.svh @@
// Assertion macros for the checker file of the pixel blend block.
`ifndef RGB565_PIXEL_BLEND_MACROS_SVH
`define RGB565_PIXEL_BLEND_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPB_ASSERT_IMP(lbl, clk_sig, rst_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("pixel blend check failed");

// Implication with a delay given by the argument n, disabled while reset is asserted.
`define RPB_ASSERT_DELAY(lbl, clk_sig, rst_sig, ante, n, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> ##n (cons)) \
        else $error("pixel blend check failed");

`endif

@@ rtl/core/rpb_pkg.sv @@
package rpb_pkg;

    // Field widths of the pixel format and of the configuration port.
    localparam int PIX_W   = 16;
    localparam int R_W     = 5;
    localparam int G_W     = 6;
    localparam int B_W     = 5;
    localparam int WGT_W   = 9;
    localparam int IDX_W   = 3;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_BLEND_MODE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_ALPHA        = 3'd1;
    localparam logic [IDX_W-1:0] REG_OPTION_BITS  = 3'd2;
    localparam logic [IDX_W-1:0] REG_KEY_COLOR    = 3'd3;
    localparam logic [IDX_W-1:0] REG_SOLID_COLOR  = 3'd4;
    localparam logic [IDX_W-1:0] REG_SOLID_SOURCE = 3'd5;

    // Bit positions inside option_bits.
    localparam int OPT_SWAP  = 0;
    localparam int OPT_KEY   = 1;
    localparam int OPT_BG    = 2;

    // Blend modes.
    typedef enum logic [1:0] {
        MODE_DIV255     = 2'd0,
        MODE_SHR8       = 2'd1,
        MODE_SAT_ADD    = 2'd2,
        MODE_SCALED_ADD = 2'd3
    } mode_t;

    // Configuration register contents.
    typedef struct packed {
        logic [1:0]       blend_mode;
        logic [7:0]       alpha;
        logic [2:0]       option_bits;
        logic [PIX_W-1:0] key_color;
        logic [PIX_W-1:0] solid_color;
        logic             solid_source;
    } cfg_t;

    // Exchanges the two bytes of a pixel.
    function automatic logic [PIX_W-1:0] byte_swap16(input logic [PIX_W-1:0] p);
        return {p[7:0], p[15:8]};
    endfunction

endpackage

@@ rtl/core/rpb_cfg.sv @@
module rpb_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [rpb_pkg::IDX_W-1:0] wr_index,
    input  logic [rpb_pkg::PIX_W-1:0] wr_data,
    output rpb_pkg::cfg_t             cfg
);
    import rpb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register write decode; indexes beyond the list leave everything unchanged.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_BLEND_MODE:   cfg_next.blend_mode   = wr_data[1:0];
                REG_ALPHA:        cfg_next.alpha        = wr_data[7:0];
                REG_OPTION_BITS:  cfg_next.option_bits  = wr_data[2:0];
                REG_KEY_COLOR:    cfg_next.key_color    = wr_data;
                REG_SOLID_COLOR:  cfg_next.solid_color  = wr_data;
                REG_SOLID_SOURCE: cfg_next.solid_source = wr_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // Register file with its reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blend_mode   <= MODE_SHR8;
            cfg_reg.alpha        <= 8'd255;
            cfg_reg.option_bits  <= 3'd0;
            cfg_reg.key_color    <= '0;
            cfg_reg.solid_color  <= '0;
            cfg_reg.solid_source <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/rpb_chan.sv @@
module rpb_chan #(
    parameter int CH_W = rpb_pkg::G_W
) (
    input  logic [CH_W-1:0]           src,
    input  logic [CH_W-1:0]           dst,
    input  logic [rpb_pkg::WGT_W-1:0] src_wgt,
    input  logic [rpb_pkg::WGT_W-1:0] dst_wgt,
    input  rpb_pkg::mode_t            mode,
    output logic [CH_W-1:0]           mixed
);
    import rpb_pkg::*;

    localparam int SUM_W = CH_W + WGT_W;

    logic [SUM_W-1:0] sum;
    logic [SUM_W:0]   div_acc;
    logic [SUM_W-1:0] pre_sat;

    // Weighted sum of source and destination; both products stay below 2^(SUM_W-1).
    assign sum = SUM_W'(src) * SUM_W'(src_wgt) + SUM_W'(dst) * SUM_W'(dst_wgt);

    // Exact division by 255 for sums below 65535: (x + (x >> 8) + 1) >> 8.
    assign div_acc = {1'b0, sum} + (SUM_W+1)'(sum >> 8) + (SUM_W+1)'(1);

    // Normalize according to the blend mode.
    always_comb
    begin
        unique case (mode)
            MODE_DIV255:  pre_sat = SUM_W'(div_acc >> 8);
            MODE_SAT_ADD: pre_sat = sum;
            default:      pre_sat = sum >> 8;
        endcase
    end

    // Clamp to the channel range.
    assign mixed = (pre_sat > SUM_W'({CH_W{1'b1}})) ? {CH_W{1'b1}} : pre_sat[CH_W-1:0];

endmodule

@@ rtl/core/rgb565_pixel_blend.sv @@
// RGB565 pixel blender. One pixel is accepted on every clock at which start is
// high; busy is always low, so a new pixel may follow in every cycle. Each
// pixel produces exactly one result: it is held first in the input register
// and then passes through the blend logic into the result register. done is
// high for a single cycle per result, together with result_pixel, write_enable
// and last_out; the receiver cannot stall and must
// take the transaction in that cycle. Configuration registers are written
// through wr_en, wr_index and wr_data and take effect on the next clock; write
// them only while no pixel is in flight.
module rgb565_pixel_blend (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [rpb_pkg::PIX_W-1:0] source_pixel,
    input  logic [rpb_pkg::PIX_W-1:0] dest_pixel,
    input  logic                      last_in_span,
    input  logic                      wr_en,
    input  logic [rpb_pkg::IDX_W-1:0] wr_index,
    input  logic [rpb_pkg::PIX_W-1:0] wr_data,
    output logic                      done,
    output logic [rpb_pkg::PIX_W-1:0] result_pixel,
    output logic                      write_enable,
    output logic                      last_out
);
    import rpb_pkg::*;

    cfg_t cfg;

    logic             in_valid_reg;
    logic [PIX_W-1:0] src_reg;
    logic [PIX_W-1:0] dst_reg;
    logic             last_reg;

    logic             done_reg;
    logic [PIX_W-1:0] result_pixel_reg;
    logic             write_enable_reg;
    logic             last_out_reg;

    logic             accept;
    logic [PIX_W-1:0] src_sel;
    logic [PIX_W-1:0] dst_sel;
    logic             key_hit;
    logic             swap_en;
    mode_t            mode;
    logic [WGT_W-1:0] src_wgt;
    logic [WGT_W-1:0] dst_wgt;
    logic [R_W-1:0]   red;
    logic [G_W-1:0]   green;
    logic [B_W-1:0]   blue;
    logic [PIX_W-1:0] packed_pix;
    logic [PIX_W-1:0] result_pixel_next;

    // Configuration registers.
    rpb_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Input register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_reg  <= source_pixel;
            dst_reg  <= dest_pixel;
            last_reg <= last_in_span;
        end
    end

    // Source and destination selection plus color key compare.
    assign swap_en = cfg.option_bits[OPT_SWAP];
    assign src_sel = cfg.solid_source ? cfg.solid_color : src_reg;
    assign key_hit = cfg.option_bits[OPT_KEY] && (src_sel == cfg.key_color);
    assign dst_sel = cfg.option_bits[OPT_BG] ? cfg.solid_color
                   : (swap_en ? byte_swap16(dst_reg) : dst_reg);

    // Source and destination weights per blend mode.
    assign mode = mode_t'(cfg.blend_mode);

    always_comb
    begin
        unique case (mode)
            MODE_DIV255:
            begin
                src_wgt = {1'b0, cfg.alpha};
                dst_wgt = WGT_W'(255) - {1'b0, cfg.alpha};
            end
            MODE_SHR8:
            begin
                src_wgt = {1'b0, cfg.alpha};
                dst_wgt = WGT_W'(256) - {1'b0, cfg.alpha};
            end
            MODE_SAT_ADD:
            begin
                src_wgt = WGT_W'(1);
                dst_wgt = WGT_W'(1);
            end
            default:
            begin
                src_wgt = {1'b0, cfg.alpha} + WGT_W'(1);
                dst_wgt = WGT_W'(256);
            end
        endcase
    end

    // One blend unit per color channel.
    rpb_chan #(.CH_W(R_W)) u_red (
        .src     (src_sel[15:11]),
        .dst     (dst_sel[15:11]),
        .src_wgt (src_wgt),
        .dst_wgt (dst_wgt),
        .mode    (mode),
        .mixed   (red)
    );

    rpb_chan #(.CH_W(G_W)) u_green (
        .src     (src_sel[10:5]),
        .dst     (dst_sel[10:5]),
        .src_wgt (src_wgt),
        .dst_wgt (dst_wgt),
        .mode    (mode),
        .mixed   (green)
    );

    rpb_chan #(.CH_W(B_W)) u_blue (
        .src     (src_sel[4:0]),
        .dst     (dst_sel[4:0]),
        .src_wgt (src_wgt),
        .dst_wgt (dst_wgt),
        .mode    (mode),
        .mixed   (blue)
    );

    // Repack, restore byte order, and pass the stored pixel through on a key match.
    assign packed_pix = {red, green, blue};
    assign result_pixel_next = key_hit ? dst_reg
                             : (swap_en ? byte_swap16(packed_pix) : packed_pix);

    // Result register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            result_pixel_reg <= result_pixel_next;
            write_enable_reg <= !key_hit;
            last_out_reg     <= last_reg;
        end
    end

    assign done         = done_reg;
    assign result_pixel = result_pixel_reg;
    assign write_enable = write_enable_reg;
    assign last_out     = last_out_reg;

endmodule

@@ rtl/core/rpb_check.sv @@
`include "rgb565_pixel_blend_macros.svh"

module rpb_check (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [rpb_pkg::PIX_W-1:0] dest_pixel,
    input logic                      last_in_span,
    input logic                      done,
    input logic [rpb_pkg::PIX_W-1:0] result_pixel,
    input logic                      write_enable,
    input logic                      last_out
);
    import rpb_pkg::*;

    // Every accepted pixel yields a result transaction.
    `RPB_ASSERT_DELAY(a_accept_done, clk, rst_n, start && !busy, 2, done)

    // A result transaction only follows an accepted pixel.
    `RPB_ASSERT_IMP(a_done_origin, clk, rst_n, done, $past(start && !busy, 2))

    // The span marker travels with its pixel.
    `RPB_ASSERT_IMP(a_last_follow, clk, rst_n, done, last_out == $past(last_in_span, 2))

    // A suppressed write hands back the stored pixel unchanged.
    `RPB_ASSERT_IMP(a_key_keeps_dest, clk, rst_n, done && !write_enable,
        result_pixel == $past(dest_pixel, 2))

endmodule

bind rgb565_pixel_blend rpb_check u_rpb_check (.*);
